@@ rtl/dgc_pkg.sv @@
// Shared types, constants and geometry helpers for the disk geometry CHS calculator.
// Used by the sequencer, the datapath and the top level. No dependencies.
`default_nettype none

package dgc_pkg;

  localparam int SIZE_W  = 21;
  localparam int COUNT_W = 22;
  localparam int PROD_W  = 44;
  localparam int SECT_W  = 31;
  localparam int CMP_W   = 40;

  localparam logic [SECT_W-1:0] SECT_SAT     = 31'h7FFF_FFFF;
  localparam logic [15:0]       BLK_SAT      = 16'hFFFF;
  localparam logic [PROD_W:0]   ROUND_ADD    = 45'd511;
  localparam logic [2:0]        HEAD_LAST    = 3'd4;
  localparam logic [1:0]        SECT_LAST    = 2'd3;
  localparam logic [2:0]        CYL_MAX_IDX  = 3'd5;
  localparam logic [2:0]        FB_HEAD_IDX  = 3'd3;
  localparam logic [1:0]        FB_SECT_IDX  = 2'd3;
  localparam logic [10:0]       CYL_MAX      = 11'h3FF;
  localparam logic [10:0]       CYL_FALLBACK = 11'h400;
  localparam logic [3:0]        DIV_LAST     = 4'd15;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROUND,
    ST_SEARCH,
    ST_SATCHK,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic round;
    logic search;
    logic satchk;
    logic divide;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic search_done;
    logic sat_hit;
    logic div_last;
  } stat_t;

  function automatic logic [8:0] heads_of(input logic [2:0] idx);
    heads_of = 9'd16 << idx;
  endfunction

  function automatic logic [5:0] sects_of(input logic [1:0] idx);
    sects_of = 6'd4 << idx;
  endfunction

  function automatic logic [10:0] cyls_of(input logic [2:0] idx, input logic fb);
    if (fb) begin
      cyls_of = CYL_FALLBACK;
    end else if (idx == CYL_MAX_IDX) begin
      cyls_of = CYL_MAX;
    end else begin
      cyls_of = 11'd32 << idx;
    end
  endfunction

  // Heads, sectors and cylinders are powers of two except the largest cylinder
  // count, so the product is one shift, or a shift minus one shift.
  function automatic logic [23:0] geom_product(input logic [2:0] hi, input logic [1:0] si,
                                               input logic [2:0] ci);
    logic [4:0] e;
    e = 5'd6 + {2'b0, hi} + {3'b0, si};
    if (ci == CYL_MAX_IDX) begin
      geom_product = (24'd1 << (e + 5'd10)) - (24'd1 << e);
    end else begin
      geom_product = 24'd1 << (e + 5'd5 + {2'b0, ci});
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/disk_geometry_chs_calc_unit.sv @@
// Top level of the disk geometry CHS calculator.
// Depends on dgc_pkg, dgc_fsm and dgc_dp.
//
// A request is taken on a clock edge where start is high and busy is low; it
// carries in_block_size. The end sector ((block_count+1)*size+511)/512 is
// formed, a head/sector/cylinder geometry is searched, the 16-bit block count
// is divided out and the CHS address of the last sector is produced.
// The block count register is written through cfg_valid/cfg_ready/
// cfg_block_count; cfg_ready is high only while the block is idle.
// One shared 40-bit subtract/compare unit serves the geometry search (up to
// 26 steps), the saturation check and a 16-step restoring division.
// Busy stays high for the whole request, so one request is in flight at a time.
// A new request can be taken at the edge that ends the strobe cycle.
// The result appears on the out_ ports for one cycle marked by out_strobe;
// the receiver cannot stall it. Reset clears the sequencer and the block
// count register, and no strobe is pending afterwards.
`default_nettype none

module disk_geometry_chs_calc_unit (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire [dgc_pkg::SIZE_W-1:0]    in_block_size,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [dgc_pkg::COUNT_W-1:0]   cfg_block_count,
  output logic                         out_strobe,
  output logic [8:0]                   out_heads,
  output logic [5:0]                   out_sectors_per_track,
  output logic [10:0]                  out_cylinders,
  output logic [15:0]                  out_short_block_count,
  output logic [7:0]                   out_end_head,
  output logic [7:0]                   out_end_sector_code,
  output logic [7:0]                   out_end_cylinder_low,
  output logic [dgc_pkg::SECT_W-1:0]   out_total_sectors,
  output logic                         out_overflow
);
  import dgc_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  assign cfg_ready = !busy;

  dgc_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  dgc_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .ctrl                  (ctrl),
    .stat                  (stat),
    .cfg_we                (cfg_valid && cfg_ready),
    .cfg_data              (cfg_block_count),
    .in_block_size         (in_block_size),
    .out_strobe            (out_strobe),
    .out_heads             (out_heads),
    .out_sectors_per_track (out_sectors_per_track),
    .out_cylinders         (out_cylinders),
    .out_short_block_count (out_short_block_count),
    .out_end_head          (out_end_head),
    .out_end_sector_code   (out_end_sector_code),
    .out_end_cylinder_low  (out_end_cylinder_low),
    .out_total_sectors     (out_total_sectors),
    .out_overflow          (out_overflow)
  );

endmodule

`default_nettype wire

@@ rtl/dgc_fsm.sv @@
// Sequencer for the disk geometry CHS calculator.
// Depends on dgc_pkg for the state and control types.
`default_nettype none

module dgc_fsm (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             start,
  input  dgc_pkg::stat_t  stat,
  output dgc_pkg::ctrl_t  ctrl,
  output logic            busy
);
  import dgc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_MUL;
      end
      ST_MUL:    state_nxt = ST_ROUND;
      ST_ROUND:  state_nxt = ST_SEARCH;
      ST_SEARCH: begin
        if (stat.search_done) state_nxt = ST_SATCHK;
      end
      ST_SATCHK: begin
        state_nxt = stat.sat_hit ? ST_FINISH : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (stat.div_last) state_nxt = ST_FINISH;
      end
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy      = 1'b0;
        ctrl.load = start;
      end
      ST_MUL:    ctrl.mul    = 1'b1;
      ST_ROUND:  ctrl.round  = 1'b1;
      ST_SEARCH: ctrl.search = 1'b1;
      ST_SATCHK: ctrl.satchk = 1'b1;
      ST_DIVIDE: ctrl.divide = 1'b1;
      ST_FINISH: ctrl.finish = 1'b1;
      default:   busy = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/dgc_dp.sv @@
// Datapath of the disk geometry CHS calculator: multiplier, one shared
// subtract/compare unit for search, saturation and division, and result registers.
// Depends on dgc_pkg for types, constants and geometry helpers.
`default_nettype none

module dgc_dp (
  input  wire                          clk,
  input  wire                          rst_n,
  input  dgc_pkg::ctrl_t               ctrl,
  output dgc_pkg::stat_t               stat,
  input  wire                          cfg_we,
  input  wire [dgc_pkg::COUNT_W-1:0]   cfg_data,
  input  wire [dgc_pkg::SIZE_W-1:0]    in_block_size,
  output logic                         out_strobe,
  output logic [8:0]                   out_heads,
  output logic [5:0]                   out_sectors_per_track,
  output logic [10:0]                  out_cylinders,
  output logic [15:0]                  out_short_block_count,
  output logic [7:0]                   out_end_head,
  output logic [7:0]                   out_end_sector_code,
  output logic [7:0]                   out_end_cylinder_low,
  output logic [dgc_pkg::SECT_W-1:0]   out_total_sectors,
  output logic                         out_overflow
);
  import dgc_pkg::*;

  logic [COUNT_W-1:0] count_r;
  logic [SIZE_W-1:0]  size_r;
  logic [PROD_W-1:0]  prod_r;
  logic [SECT_W-1:0]  end_r;
  logic               ovf_r;
  logic [2:0]         hi_r;
  logic [1:0]         si_r;
  logic [2:0]         ci_r;
  logic               fb_r;
  logic               chk_max_r;
  logic [SIZE_W-1:0]  rem_r;
  logic [15:0]        dlo_r;
  logic [15:0]        quo_r;
  logic [3:0]         cnt_r;
  logic               strobe_r;

  logic [PROD_W:0]    rounded;
  logic [35:0]        raw;
  logic [CMP_W-1:0]   opa, opb;
  logic [CMP_W:0]     diff;
  logic               borrow;
  logic [SIZE_W:0]    div_trial;

  logic [SECT_W-1:0]  lba, lba_h, cyl;
  logic [2:0]         sh_s;
  logic [3:0]         sh_hs;
  logic [8:0]         hmask;
  logic [5:0]         smask, sec;
  logic [7:0]         eh_nxt, es_nxt, ec_nxt;

  assign rounded   = {1'b0, prod_r} + ROUND_ADD;
  assign raw       = rounded[PROD_W:9];
  assign div_trial = {rem_r, dlo_r[15]};

  always_comb begin
    opa = '0;
    opb = '0;
    if (ctrl.search) begin
      opa = {9'b0, end_r};
      opb = {16'b0, geom_product(hi_r, si_r, ci_r)};
    end else if (ctrl.satchk) begin
      opa = {end_r, 9'b0};
      opb = {3'b0, size_r, 16'b0};
    end else if (ctrl.divide) begin
      opa = {18'b0, div_trial};
      opb = {19'b0, size_r};
    end
  end

  assign diff   = {1'b0, opa} - {1'b0, opb};
  assign borrow = diff[CMP_W];

  assign stat.search_done = ctrl.search &&
                            ((chk_max_r && !borrow && si_r == SECT_LAST && hi_r == HEAD_LAST) ||
                             (!chk_max_r && borrow));
  assign stat.sat_hit     = ctrl.satchk && !borrow;
  assign stat.div_last    = ctrl.divide && cnt_r == DIV_LAST;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_we) begin
      count_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) size_r <= in_block_size;
    if (ctrl.mul) prod_r <= ({1'b0, count_r} + 23'd1) * size_r;
    if (ctrl.round) begin
      ovf_r     <= |raw[35:SECT_W];
      end_r     <= (|raw[35:SECT_W]) ? SECT_SAT : raw[SECT_W-1:0];
      hi_r      <= '0;
      si_r      <= '0;
      ci_r      <= CYL_MAX_IDX;
      fb_r      <= 1'b0;
      chk_max_r <= 1'b1;
    end
    if (ctrl.search) begin
      if (chk_max_r) begin
        if (borrow) begin
          ci_r      <= '0;
          chk_max_r <= 1'b0;
        end else if (si_r == SECT_LAST) begin
          if (hi_r == HEAD_LAST) begin
            fb_r <= 1'b1;
            hi_r <= FB_HEAD_IDX;
            si_r <= FB_SECT_IDX;
          end else begin
            hi_r <= hi_r + 3'd1;
            si_r <= '0;
          end
        end else begin
          si_r <= si_r + 2'd1;
        end
      end else if (!borrow) begin
        ci_r <= ci_r + 3'd1;
      end
    end
    if (ctrl.satchk) begin
      quo_r <= borrow ? 16'd0 : BLK_SAT;
      rem_r <= end_r[27:7];
      dlo_r <= {end_r[6:0], 9'b0};
      cnt_r <= '0;
    end
    if (ctrl.divide) begin
      rem_r <= borrow ? div_trial[SIZE_W-1:0] : diff[SIZE_W-1:0];
      quo_r <= {quo_r[14:0], ~borrow};
      dlo_r <= {dlo_r[14:0], 1'b0};
      cnt_r <= cnt_r + 4'd1;
    end
  end

  always_comb begin
    lba    = end_r - 31'd1;
    sh_s   = 3'd2 + {1'b0, si_r};
    sh_hs  = 4'd6 + {1'b0, hi_r} + {2'b0, si_r};
    lba_h  = lba >> sh_s;
    cyl    = lba >> sh_hs;
    hmask  = heads_of(hi_r) - 9'd1;
    smask  = sects_of(si_r) - 6'd1;
    sec    = (lba[5:0] & smask) + 6'd1;
    eh_nxt = lba_h[7:0] & hmask[7:0];
    es_nxt = {cyl[9:8], sec};
    ec_nxt = cyl[7:0];
    if (end_r == '0) begin
      eh_nxt = '0;
      es_nxt = '0;
      ec_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      out_heads             <= fb_r ? heads_of(FB_HEAD_IDX) : heads_of(hi_r);
      out_sectors_per_track <= fb_r ? sects_of(FB_SECT_IDX) : sects_of(si_r);
      out_cylinders         <= cyls_of(ci_r, fb_r);
      out_short_block_count <= quo_r;
      out_end_head          <= eh_nxt;
      out_end_sector_code   <= es_nxt;
      out_end_cylinder_low  <= ec_nxt;
      out_total_sectors     <= end_r;
      out_overflow          <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctrl.finish;
    end
  end

  assign out_strobe = strobe_r;

endmodule

`default_nettype wire

@@ rtl/dgc_checker.sv @@
// Port-level checks for the disk geometry CHS calculator, bound to its top level.
// Depends on disk_geometry_chs_calc_unit and dgc_pkg.
`default_nettype none

module dgc_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          start,
  input wire                          busy,
  input wire                          cfg_ready,
  input wire                          out_strobe,
  input wire [8:0]                    out_heads,
  input wire [dgc_pkg::SECT_W-1:0]    out_total_sectors,
  input wire                          out_overflow
);
  import dgc_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted request");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe lasted more than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy && cfg_ready && $past(busy))
    else $error("result strobe not at the end of a request");

  a_heads_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_heads == 9'd16 || out_heads == 9'd32 || out_heads == 9'd64 ||
                   out_heads == 9'd128 || out_heads == 9'd256)
    else $error("illegal head count");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_overflow |-> out_total_sectors == SECT_SAT)
    else $error("overflow without saturated sector count");

endmodule

bind disk_geometry_chs_calc_unit dgc_checker u_dgc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .cfg_ready         (cfg_ready),
  .out_strobe        (out_strobe),
  .out_heads         (out_heads),
  .out_total_sectors (out_total_sectors),
  .out_overflow      (out_overflow)
);

`default_nettype wire
